@@ rtl/hsc_pkg.sv @@
// Shared types, constants and column table for the Hamming SEC codec.
package hsc_pkg;

    localparam int DATA_BITS   = 11;
    localparam int PARITY_BITS = 4;
    localparam int CODE_BITS   = DATA_BITS + PARITY_BITS;

    typedef enum logic
    {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    typedef logic [DATA_BITS-1:0]   data_t;
    typedef logic [CODE_BITS-1:0]   code_t;
    typedef logic [PARITY_BITS-1:0] syn_t;

    typedef logic [CODE_BITS-1:0][PARITY_BITS-1:0] column_table_t;

    // Input word as held in the input register
    typedef struct packed
    {
        kind_t kind;
        data_t data_in;
        code_t code_in;
    } cmd_word_t;

    // Result word as produced by the datapath
    typedef struct packed
    {
        code_t code_out;
        data_t data_out;
        syn_t  syndrome;
        logic  corrected;
        logic  uncorrectable;
    } res_word_t;

    // Column value of every codeword position. Data columns skip powers of two
    // and are handed out from the top data bit down; check bit j sits at
    // 2^(PARITY_BITS-1-j).
    function automatic column_table_t build_columns();
        column_table_t tbl;
        int            v;
        int            i;
        int            j;
        tbl = '0;
        v   = 3;
        for (i = DATA_BITS - 1; i >= 0; i--)
        begin
            if ((v & (v - 1)) == 0)
            begin
                v++;
            end
            tbl[i] = PARITY_BITS'(v);
            v++;
        end
        for (j = 0; j < PARITY_BITS; j++)
        begin
            tbl[DATA_BITS + j] = PARITY_BITS'(1 << (PARITY_BITS - 1 - j));
        end
        return tbl;
    endfunction

    localparam column_table_t COLUMNS = build_columns();

endpackage

@@ rtl/hsc_cmd_if.sv @@
// Command channel interface: operation kind plus data or codeword.
interface hsc_cmd_if;
    logic              valid;
    logic              ready;
    hsc_pkg::kind_t    kind;
    hsc_pkg::data_t    data_in;
    hsc_pkg::code_t    code_in;

    modport source
    (
        output valid, kind, data_in, code_in,
        input  ready
    );

    modport sink
    (
        input  valid, kind, data_in, code_in,
        output ready
    );
endinterface

@@ rtl/hsc_res_if.sv @@
// Result channel interface: codeword, data, syndrome and status flags.
interface hsc_res_if;
    logic              valid;
    logic              ready;
    hsc_pkg::code_t    code_out;
    hsc_pkg::data_t    data_out;
    hsc_pkg::syn_t     syndrome;
    logic              corrected;
    logic              uncorrectable;

    modport source
    (
        output valid, code_out, data_out, syndrome, corrected, uncorrectable,
        input  ready
    );

    modport sink
    (
        input  valid, code_out, data_out, syndrome, corrected, uncorrectable,
        output ready
    );
endinterface

@@ rtl/hsc_datapath.sv @@
// Combinational encode / syndrome / single-bit correction datapath.
module hsc_datapath
(
    input  hsc_pkg::cmd_word_t cmd_word,
    output hsc_pkg::res_word_t res_word
);

    hsc_pkg::code_t word;
    hsc_pkg::syn_t  syn;
    hsc_pkg::code_t hit;
    hsc_pkg::code_t enc_code;
    hsc_pkg::code_t fixed_code;
    logic           is_decode;
    logic           found;

    assign is_decode = (cmd_word.kind == hsc_pkg::KIND_DECODE);

    // Encode takes the data with zero check bits; its syndrome is the check value
    assign word = is_decode ? cmd_word.code_in
                            : {{hsc_pkg::PARITY_BITS{1'b0}}, cmd_word.data_in};

    always_comb
    begin
        syn = '0;
        for (int k = 0; k < hsc_pkg::CODE_BITS; k++)
        begin
            if (word[k])
            begin
                syn = syn ^ hsc_pkg::COLUMNS[k];
            end
        end
    end

    // Columns are distinct and nonzero, so at most one position matches
    always_comb
    begin
        hit = '0;
        for (int k = 0; k < hsc_pkg::CODE_BITS; k++)
        begin
            hit[k] = (syn == hsc_pkg::COLUMNS[k]);
        end
    end

    always_comb
    begin
        enc_code = {{hsc_pkg::PARITY_BITS{1'b0}}, cmd_word.data_in};
        for (int j = 0; j < hsc_pkg::PARITY_BITS; j++)
        begin
            enc_code[hsc_pkg::DATA_BITS + j] = syn[hsc_pkg::PARITY_BITS - 1 - j];
        end
    end

    assign found      = |hit;
    assign fixed_code = cmd_word.code_in ^ hit;

    always_comb
    begin
        if (is_decode)
        begin
            res_word.code_out      = fixed_code;
            res_word.data_out      = fixed_code[hsc_pkg::DATA_BITS-1:0];
            res_word.syndrome      = syn;
            res_word.corrected     = found;
            res_word.uncorrectable = (syn != '0) && !found;
        end
        else
        begin
            res_word.code_out      = enc_code;
            res_word.data_out      = cmd_word.data_in;
            res_word.syndrome      = '0;
            res_word.corrected     = 1'b0;
            res_word.uncorrectable = 1'b0;
        end
    end

endmodule

@@ rtl/hamming_sec_codec_unit.sv @@
// Top level of the Hamming SEC codec: input register, datapath, result register.
// An accepted word is held in the input register, passes through the datapath and
// is offered on res from the result register. Throughput: one word per cycle while
// res is ready; one XOR/compare pass sits between the input and result registers.
// Backpressure on res stalls the pipe; the input register still takes a word
// when it is empty or moving forward. Reset (rst_n low, async) clears both valids.
module hamming_sec_codec_unit
(
    input  logic             clk,
    input  logic             rst_n,
    hsc_cmd_if.sink          cmd,
    hsc_res_if.source        res
);

    // Input stage
    logic                  in_valid_reg;
    logic                  in_valid_next;
    hsc_pkg::cmd_word_t    in_word_reg;

    // Result stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hsc_pkg::res_word_t    out_word_reg;
    hsc_pkg::res_word_t    dp_word;

    logic                  cmd_fire;
    logic                  out_load;
    logic                  in_advance;

    // Result register can load when empty or being drained this cycle
    assign out_load   = !out_valid_reg || res.ready;
    assign in_advance = in_valid_reg && out_load;
    assign cmd.ready  = !in_valid_reg || out_load;
    assign cmd_fire   = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            in_word_reg.kind    <= cmd.kind;
            in_word_reg.data_in <= cmd.data_in;
            in_word_reg.code_in <= cmd.code_in;
        end
    end

    hsc_datapath u_datapath
    (
        .cmd_word (in_word_reg),
        .res_word (dp_word)
    );

    // Advance the finished word into the result register
    always_ff @(posedge clk)
    begin
        if (in_advance)
        begin
            out_word_reg <= dp_word;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.code_out      = out_word_reg.code_out;
    assign res.data_out      = out_word_reg.data_out;
    assign res.syndrome      = out_word_reg.syndrome;
    assign res.corrected     = out_word_reg.corrected;
    assign res.uncorrectable = out_word_reg.uncorrectable;

`ifndef SYNTHESIS
    // Correction and failure are exclusive
    a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_word_reg.corrected && out_word_reg.uncorrectable))
        else $error("corrected and uncorrectable both set");

    // A flip only happens on a nonzero syndrome
    a_corrected_syn : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.corrected) |-> (out_word_reg.syndrome != '0))
        else $error("corrected with zero syndrome");

    // Data field always mirrors the low codeword bits
    a_data_matches_code : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_word_reg.data_out == out_word_reg.code_out[hsc_pkg::DATA_BITS-1:0]))
        else $error("data_out differs from code_out data bits");

    // A word leaving the input stage must land in the result register
    a_advance_lands : assert property (@(posedge clk) disable iff (!rst_n)
        in_advance |=> out_valid_reg)
        else $error("advanced word lost");

    // Input stage never overwritten while holding a stalled word
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_load) |-> !cmd_fire)
        else $error("input register overwritten while stalled");
`endif

endmodule

@@ sim/tb_hamming_sec_codec_unit.sv @@
// Self-checking testbench for the Hamming SEC codec: corners, random traffic, backpressure.
`timescale 1ns / 1ps

module tb_hamming_sec_codec_unit;

    // Pipe is two registers deep: the input register, then the result register that drives res.
    localparam int PIPE_LATENCY     = 2;
    localparam int DRAIN_CYCLES     = PIPE_LATENCY + 8;
    localparam int RANDOM_WORDS     = 1150;
    localparam int LONG_HOLD_CYCLES = 300;
    // Longest legal quiet stretch is the long hold plus a sender gap; take it
    // many times over.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 10;

    logic clk = 1'b0;
    logic rst_n;

    hsc_cmd_if cmd_bus ();
    hsc_res_if res_bus ();

    hamming_sec_codec_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results predicted for accepted words, oldest first
    hsc_pkg::res_word_t pending_results[$];

    int  words_in       = 0;
    int  words_out      = 0;
    int  error_count    = 0;
    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  encodes_seen   = 0;
    int  clean_decodes  = 0;
    int  fixed_decodes  = 0;
    int  unfixable_seen = 0;
    int  long_holds     = 0;

    // Sender pacing
    int  burst_left     = 0;
    bit  gaps_on        = 1'b1;
    // Set by a test to ask the receiver for one long hold-off
    bit  long_hold_req  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Column value of a codeword position. Data columns skip powers of two and
    // run from the top data bit down; check bit j sits at 2^(PARITY_BITS-1-j).
    function automatic hsc_pkg::syn_t column_value(int pos);
        int v;
        int i;
        if (pos >= hsc_pkg::DATA_BITS)
        begin
            return hsc_pkg::syn_t'(1 << (hsc_pkg::PARITY_BITS - 1 -
                                         (pos - hsc_pkg::DATA_BITS)));
        end
        v = 3;
        for (i = hsc_pkg::DATA_BITS - 1; i >= 0; i--)
        begin
            while ((v & (v - 1)) == 0)
            begin
                v++;
            end
            if (i == pos)
            begin
                return hsc_pkg::syn_t'(v);
            end
            v++;
        end
        return '0;
    endfunction

    // XOR of the columns of all set bits
    function automatic hsc_pkg::syn_t code_syndrome(hsc_pkg::code_t word);
        hsc_pkg::syn_t s;
        int            k;
        s = '0;
        for (k = 0; k < hsc_pkg::CODE_BITS; k++)
        begin
            if (word[k])
            begin
                s ^= column_value(k);
            end
        end
        return s;
    endfunction

    function automatic hsc_pkg::res_word_t hamming_predict(hsc_pkg::kind_t op,
                                                           hsc_pkg::data_t d,
                                                           hsc_pkg::code_t c);
        hsc_pkg::res_word_t r;
        hsc_pkg::syn_t      chk;
        int                 j;
        int                 k;
        bit                 found;
        r = '0;
        if (op == hsc_pkg::KIND_ENCODE)
        begin
            // Data columns alone give the check bits; place them above the data.
            chk        = code_syndrome(hsc_pkg::code_t'(d));
            r.code_out = hsc_pkg::code_t'(d);
            for (j = 0; j < hsc_pkg::PARITY_BITS; j++)
            begin
                r.code_out[hsc_pkg::DATA_BITS + j] = chk[hsc_pkg::PARITY_BITS - 1 - j];
            end
            r.data_out = d;
        end
        else
        begin
            r.syndrome = code_syndrome(c);
            found      = 1'b0;
            if (r.syndrome != '0)
            begin
                // Flip the first position whose column matches the syndrome
                for (k = 0; k < hsc_pkg::CODE_BITS; k++)
                begin
                    if (!found && column_value(k) == r.syndrome)
                    begin
                        c[k]  = ~c[k];
                        found = 1'b1;
                    end
                end
                r.corrected     = found;
                r.uncorrectable = !found;
            end
            r.code_out = c;
            r.data_out = c[hsc_pkg::DATA_BITS-1:0];
        end
        return r;
    endfunction

    function automatic hsc_pkg::code_t codeword_of(hsc_pkg::data_t d);
        hsc_pkg::res_word_t r;
        r = hamming_predict(hsc_pkg::KIND_ENCODE, d, '0);
        return r.code_out;
    endfunction

    // Flip two distinct positions: a double error aliases onto some column
    function automatic hsc_pkg::code_t flip_two(hsc_pkg::code_t c);
        int a;
        int b;
        a = $urandom_range(0, hsc_pkg::CODE_BITS - 1);
        b = (a + $urandom_range(1, hsc_pkg::CODE_BITS - 1)) % hsc_pkg::CODE_BITS;
        c[a] = ~c[a];
        c[b] = ~c[b];
        return c;
    endfunction

    function automatic hsc_pkg::data_t random_data();
        return hsc_pkg::data_t'($urandom_range(0, (1 << hsc_pkg::DATA_BITS) - 1));
    endfunction

    function automatic hsc_pkg::code_t random_code();
        return hsc_pkg::code_t'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Sender: one word per call, in bursts with random gaps between them.
    // Called and returns at a rising edge; valid stays high across words of
    // a burst, so it is never dropped and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_word(hsc_pkg::kind_t op, hsc_pkg::data_t d, hsc_pkg::code_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_bus.valid   <= 1'b1;
        cmd_bus.kind    <= op;
        cmd_bus.data_in <= d;
        cmd_bus.code_in <= c;
        // Hold until the block takes the word
        @(posedge clk);
        while (!cmd_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encode all-zero, all-one, alternating and single-bit data words
    task automatic test_encode_corners();
        send_word(hsc_pkg::KIND_ENCODE, '0, random_code());
        send_word(hsc_pkg::KIND_ENCODE, '1, random_code());
        send_word(hsc_pkg::KIND_ENCODE, hsc_pkg::data_t'(11'h555), random_code());
        send_word(hsc_pkg::KIND_ENCODE, hsc_pkg::data_t'(11'h2AA), random_code());
        send_word(hsc_pkg::KIND_ENCODE, hsc_pkg::data_t'(1), random_code());
        send_word(hsc_pkg::KIND_ENCODE,
                  hsc_pkg::data_t'(1) << (hsc_pkg::DATA_BITS - 1), random_code());
    endtask

    // Decode one clean codeword, then that codeword with each single bit
    // flipped, data and check positions alike
    task automatic test_decode_single_errors();
        hsc_pkg::code_t cw;
        int             pos;
        cw = codeword_of(random_data());
        send_word(hsc_pkg::KIND_DECODE, random_data(), cw);
        for (pos = 0; pos < hsc_pkg::CODE_BITS; pos++)
        begin
            send_word(hsc_pkg::KIND_DECODE, random_data(),
                      cw ^ (hsc_pkg::code_t'(1) << pos));
        end
    endtask

    // Beyond one error: a double flip, all-one and all-zero received words.
    // Every nonzero syndrome has a column at this size, so the unfixable flag
    // is only checked to stay low here.
    task automatic test_decode_multi_errors();
        send_word(hsc_pkg::KIND_DECODE, random_data(),
                  flip_two(codeword_of(random_data())));
        send_word(hsc_pkg::KIND_DECODE, random_data(), '1);
        send_word(hsc_pkg::KIND_DECODE, random_data(), '0);
    endtask

    // Mostly well-formed codewords with zero, one or two flips, plus encodes
    // and raw noise. Switch sender gaps off now and then for solid streams.
    task automatic test_random_mix();
        int             n;
        int             sel;
        hsc_pkg::code_t cw;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 200 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                send_word(hsc_pkg::KIND_ENCODE, random_data(), random_code());
            end
            else
            begin
                cw = codeword_of(random_data());
                if (sel >= 50 && sel < 80)
                begin
                    cw[$urandom_range(0, hsc_pkg::CODE_BITS - 1)] ^= 1'b1;
                end
                else if (sel >= 80 && sel < 90)
                begin
                    cw = flip_two(cw);
                end
                else if (sel >= 90)
                begin
                    cw = random_code();
                end
                send_word(hsc_pkg::KIND_DECODE, random_data(), cw);
            end
        end
        gaps_on = 1'b1;
    endtask

    // Ask for a long hold on res and keep offering words so the pipe fills
    // and cmd.ready drops
    task automatic test_backpressure();
        int n;
        long_hold_req = 1'b1;
        gaps_on       = 1'b0;
        for (n = 0; n < 40; n++)
        begin
            send_word(hsc_pkg::kind_t'($urandom_range(0, 1)), random_data(), random_code());
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.kind    = hsc_pkg::KIND_ENCODE;
        cmd_bus.data_in = '0;
        cmd_bus.code_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_corners();
        test_decode_single_errors();
        test_decode_multi_errors();
        test_backpressure();
        test_random_mix();

        // Drop valid, drain what is still in flight, then let the pipe settle
        // so a stray extra result would be caught
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words, checked %0d: %0d encodes, %0d clean decodes,",
                 words_in, words_out, encodes_seen, clean_decodes);
        $display("%0d corrected, %0d unfixable; %0d long receiver holds, %0d mismatches",
                 fixed_decodes, unfixable_seen, long_holds, mismatch_count);
        if (error_count == 0)
        begin
            $display("tb_hamming_sec_codec_unit: done, clean");
        end
        else
        begin
            $display("tb_hamming_sec_codec_unit: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver pacing: a pattern that steps in turn through always ready, mostly
    // ready, regular on/off toggling and mostly stalled, plus a long hold on request
    // ------------------------------------------------------------------
    initial
    begin : sink_pace
        logic [7:0] pace_cycle;
        pace_cycle    = '0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_holds++;
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                pace_cycle++;
                case (pace_cycle[7:6])
                    2'd0:    res_bus.ready <= 1'b1;
                    2'd1:    res_bus.ready <= ($urandom_range(0, 3) != 0);
                    2'd2:    res_bus.ready <= pace_cycle[1];
                    default: res_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Predict on every accepted command word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
        begin
            pending_results.push_back(
                hamming_predict(cmd_bus.kind, cmd_bus.data_in, cmd_bus.code_in));
            words_in++;
        end
    end

    task automatic note_mismatch(string what, hsc_pkg::res_word_t want,
                                 hsc_pkg::res_word_t got);
        error_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s at result %0d", $realtime, what, words_out);
            $display("    expected code=%h data=%h syn=%h corr=%b unc=%b",
                     want.code_out, want.data_out, want.syndrome,
                     want.corrected, want.uncorrectable);
            $display("    actual   code=%h data=%h syn=%h corr=%b unc=%b",
                     got.code_out, got.data_out, got.syndrome,
                     got.corrected, got.uncorrectable);
        end
    endtask

    // ------------------------------------------------------------------
    // Check every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        hsc_pkg::res_word_t got;
        hsc_pkg::res_word_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.code_out      = res_bus.code_out;
            got.data_out      = res_bus.data_out;
            got.syndrome      = res_bus.syndrome;
            got.corrected     = res_bus.corrected;
            got.uncorrectable = res_bus.uncorrectable;
            if (pending_results.size() == 0)
            begin
                note_mismatch("result with nothing pending", '0, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.code_out !== want.code_out || got.data_out !== want.data_out ||
                    got.syndrome !== want.syndrome || got.corrected !== want.corrected ||
                    got.uncorrectable !== want.uncorrectable)
                begin
                    note_mismatch("result mismatch", want, got);
                end
                // Tally what was covered from the prediction, not the block
                if (want.uncorrectable)
                begin
                    unfixable_seen++;
                end
                else if (want.corrected)
                begin
                    fixed_decodes++;
                end
            end
            words_out++;
        end
    end

    // Count encodes and clean decodes at the input side, where the kind is known
    always @(posedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
        begin
            if (cmd_bus.kind == hsc_pkg::KIND_ENCODE)
            begin
                encodes_seen++;
            end
            else if (code_syndrome(cmd_bus.code_in) == '0)
            begin
                clean_decodes++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, pending_results.size());
                $display("tb_hamming_sec_codec_unit: done, errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

@@ sim.f @@
rtl/hsc_pkg.sv
rtl/hsc_cmd_if.sv
rtl/hsc_res_if.sv
rtl/hsc_datapath.sv
rtl/hamming_sec_codec_unit.sv
sim/tb_hamming_sec_codec_unit.sv
